FILE: hdl/alac_pkg.sv
`default_nettype none
package alac_pkg;

	localparam int CORDIC_STAGES_DEF = 16;
	localparam int MAX_STAGES        = 24;

	// Rotation datapath widths: prescaled offsets are Q16 mm and grow by the
	// CORDIC gain, so 34 bits hold them; the angle uses 2^32 units per turn.
	localparam int XW = 34;
	localparam int ZW = 33;

	// CORDIC gain compensation, 0.6072529350 in Q16.
	localparam logic signed [17:0] KG_Q16     = 18'sd39797;
	localparam logic signed [17:0] KG_Q16_NEG = -18'sd39797;

	typedef enum logic [1:0] {
		REG_OFFSET_FWD   = 2'd0,
		REG_OFFSET_RIGHT = 2'd1,
		REG_OFFSET_UP    = 2'd2,
		REG_CORRECT_EN   = 2'd3
	} reg_idx_t;

	// One slot of the cell chain: the rotation vector plus the position that
	// rides along with it.
	typedef struct packed {
		logic                 valid;
		logic                 corr;
		logic signed [31:0]   pn;
		logic signed [31:0]   pe;
		logic signed [31:0]   pd;
		logic signed [XW-1:0] x;
		logic signed [XW-1:0] y;
		logic signed [ZW-1:0] z;
	} stage_t;

	function automatic logic signed [ZW-1:0] atan_angle(input int idx);
		logic signed [ZW-1:0] a;
		case (idx)
			0:       a = 33'sh020000000;
			1:       a = 33'sh012E4051E;
			2:       a = 33'sh009FB385B;
			3:       a = 33'sh0051111D4;
			4:       a = 33'sh0028B0D43;
			5:       a = 33'sh00145D7E1;
			6:       a = 33'sh000A2F61E;
			7:       a = 33'sh000517C55;
			8:       a = 33'sh00028BE53;
			9:       a = 33'sh000145F2F;
			10:      a = 33'sh0000A2F98;
			11:      a = 33'sh0000517CC;
			12:      a = 33'sh000028BE6;
			13:      a = 33'sh0000145F3;
			14:      a = 33'sh00000A2FA;
			15:      a = 33'sh00000517D;
			16:      a = 33'sh0000028BE;
			17:      a = 33'sh00000145F;
			18:      a = 33'sh000000A30;
			19:      a = 33'sh000000518;
			20:      a = 33'sh00000028C;
			21:      a = 33'sh000000146;
			22:      a = 33'sh0000000A3;
			23:      a = 33'sh000000051;
			default: a = '0;
		endcase
		return a;
	endfunction

endpackage
`default_nettype wire

FILE: hdl/alac_prerot.sv
`default_nettype none
// Entry slot of the chain: prescales the offsets by the gain constant and
// folds the heading into the +-quarter-turn range the rotation covers.
module alac_prerot (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  en,
	input  wire logic                  in_valid,
	input  wire logic signed [31:0]    pos_north,
	input  wire logic signed [31:0]    pos_east,
	input  wire logic signed [31:0]    pos_down,
	input  wire logic signed [15:0]    heading,
	input  wire logic signed [15:0]    offset_fwd,
	input  wire logic signed [15:0]    offset_right,
	input  wire logic                  correct_enable,
	output alac_pkg::stage_t           q
);

	logic                           fold_pos;
	logic                           fold_neg;
	logic signed [17:0]             gain;
	logic signed [16:0]             hd_fold;
	logic signed [33:0]             x_pre;
	logic signed [33:0]             y_pre;
	alac_pkg::stage_t               d;

	always_comb begin
		fold_pos = (heading > 16'sd16384);
		fold_neg = (heading < -16'sd16384);
		// Negating the gain negates the vector without an extra adder.
		gain     = (fold_pos || fold_neg) ? alac_pkg::KG_Q16_NEG : alac_pkg::KG_Q16;
		if (fold_pos) begin
			hd_fold = 17'(heading) - 17'sd32768;
		end else if (fold_neg) begin
			hd_fold = 17'(heading) + 17'sd32768;
		end else begin
			hd_fold = 17'(heading);
		end
		x_pre   = offset_fwd * gain;
		y_pre   = offset_right * gain;
		d.valid = in_valid;
		d.corr  = correct_enable;
		d.pn    = pos_north;
		d.pe    = pos_east;
		d.pd    = pos_down;
		d.x     = alac_pkg::XW'(x_pre);
		d.y     = alac_pkg::XW'(y_pre);
		d.z     = {hd_fold[alac_pkg::ZW-17:0], 16'd0};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q <= '0;
		end else if (en) begin
			q <= d;
		end
	end

endmodule
`default_nettype wire

FILE: hdl/alac_cell.sv
`default_nettype none
// One CORDIC micro-rotation, registered, handing its slot to the next cell.
module alac_cell #(
	parameter int STAGE = 0
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             en,
	input  wire alac_pkg::stage_t d,
	output alac_pkg::stage_t      q
);

	localparam logic signed [alac_pkg::ZW-1:0] ANGLE = alac_pkg::atan_angle(STAGE);

	logic signed [alac_pkg::XW-1:0] xs;
	logic signed [alac_pkg::XW-1:0] ys;
	logic signed [alac_pkg::XW-1:0] x_nx;
	logic signed [alac_pkg::XW-1:0] y_nx;
	logic signed [alac_pkg::ZW-1:0] z_nx;

	always_comb begin
		xs = d.x >>> STAGE;
		ys = d.y >>> STAGE;
		if (!d.z[alac_pkg::ZW-1]) begin
			x_nx = d.x - ys;
			y_nx = d.y + xs;
			z_nx = d.z - ANGLE;
		end else begin
			x_nx = d.x + ys;
			y_nx = d.y - xs;
			z_nx = d.z + ANGLE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q <= '0;
		end else if (en) begin
			q.valid <= d.valid;
			q.corr  <= d.corr;
			q.pn    <= d.pn;
			q.pe    <= d.pe;
			q.pd    <= d.pd;
			q.x     <= x_nx;
			q.y     <= y_nx;
			q.z     <= z_nx;
		end
	end

endmodule
`default_nettype wire

FILE: hdl/antenna_lever_arm_correct.sv
// GNSS antenna lever-arm correction. Each transfer on the slave stream carries
// an antenna fix (north, east, down in mm) and the robot heading as a 16-bit
// binary angle; the configured antenna offset (forward, right, up) is rotated
// into the world frame by a chain of CORDIC cells and removed to give the robot
// centre, each component clamped to signed 32 bits with the clamp reported in
// tuser. With correct_enable clear the fix passes through unchanged. The block
// takes one transfer per cycle unless the chain is stalled; an accepted fix
// loads the prescale slot, then passes through min(CORDIC_STAGES, 24) CORDIC
// cells and then the result register. The whole chain advances together, so
// it holds while a finished result is stalled at the master side. Registers
// (APB, byte address): 0x0 offset_fwd, 0x4 offset_right, 0x8 offset_up (16-bit
// signed mm), 0xC correct_enable; write them only while no fix is in flight.
`default_nettype none
module antenna_lever_arm_correct #(
	parameter int CORDIC_STAGES = alac_pkg::CORDIC_STAGES_DEF
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	// s_tdata: pos_north[31:0], pos_east[63:32], pos_down[95:64], heading[111:96]
	input  wire logic         s_tvalid,
	output logic              s_tready,
	input  wire logic [111:0] s_tdata,
	// m_tdata: centre_north[31:0], centre_east[63:32], centre_down[95:64]
	output logic              m_tvalid,
	input  wire logic         m_tready,
	output logic [95:0]       m_tdata,
	// m_tuser: saturated[0]
	output logic              m_tuser,
	input  wire logic         psel,
	input  wire logic         penable,
	input  wire logic         pwrite,
	input  wire logic [3:0]   paddr,
	input  wire logic [31:0]  pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	localparam int NCELL = (CORDIC_STAGES > alac_pkg::MAX_STAGES) ?
		alac_pkg::MAX_STAGES : CORDIC_STAGES;

	logic signed [15:0]  offset_fwd_q;
	logic signed [15:0]  offset_right_q;
	logic signed [15:0]  offset_up_q;
	logic                correct_enable_q;
	alac_pkg::reg_idx_t  reg_idx;
	logic                cfg_wr;
	logic                en;

	alac_pkg::stage_t    chain [0:NCELL];
	alac_pkg::stage_t    last;

	logic signed [34:0]  xr;
	logic signed [34:0]  yr;
	logic signed [35:0]  cn_w;
	logic signed [35:0]  ce_w;
	logic signed [35:0]  cd_w;
	logic signed [31:0]  cn;
	logic signed [31:0]  ce;
	logic signed [31:0]  cd;
	logic                sat_n;
	logic                sat_e;
	logic                sat_d;

	logic                out_valid_q;
	logic [95:0]         out_data_q;
	logic                out_sat_q;

	function automatic logic signed [31:0] clamp32(input logic signed [35:0] v,
		output logic hit);
		logic signed [31:0] r;
		if (v > 36'sd2147483647) begin
			r   = 32'sh7FFFFFFF;
			hit = 1'b1;
		end else if (v < -36'sd2147483648) begin
			r   = 32'sh80000000;
			hit = 1'b1;
		end else begin
			r   = v[31:0];
			hit = 1'b0;
		end
		return r;
	endfunction

	// Configuration port.
	assign pready  = 1'b1;
	assign reg_idx = alac_pkg::reg_idx_t'(paddr[3:2]);
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_fwd_q     <= '0;
			offset_right_q   <= '0;
			offset_up_q      <= '0;
			correct_enable_q <= 1'b0;
		end else if (cfg_wr) begin
			case (reg_idx)
				alac_pkg::REG_OFFSET_FWD:   offset_fwd_q     <= pwdata[15:0];
				alac_pkg::REG_OFFSET_RIGHT: offset_right_q   <= pwdata[15:0];
				alac_pkg::REG_OFFSET_UP:    offset_up_q      <= pwdata[15:0];
				alac_pkg::REG_CORRECT_EN:   correct_enable_q <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			alac_pkg::REG_OFFSET_FWD:   prdata = {16'd0, offset_fwd_q};
			alac_pkg::REG_OFFSET_RIGHT: prdata = {16'd0, offset_right_q};
			alac_pkg::REG_OFFSET_UP:    prdata = {16'd0, offset_up_q};
			alac_pkg::REG_CORRECT_EN:   prdata = {31'd0, correct_enable_q};
			default:                    prdata = '0;
		endcase
	end

	// The chain moves whenever the result register is empty or being drained.
	assign en       = !out_valid_q || m_tready;
	assign s_tready = en;

	alac_prerot u_prerot (
		.clk            (clk),
		.arst_n         (arst_n),
		.en             (en),
		.in_valid       (s_tvalid),
		.pos_north      (s_tdata[31:0]),
		.pos_east       (s_tdata[63:32]),
		.pos_down       (s_tdata[95:64]),
		.heading        (s_tdata[111:96]),
		.offset_fwd     (offset_fwd_q),
		.offset_right   (offset_right_q),
		.correct_enable (correct_enable_q),
		.q              (chain[0])
	);

	for (genvar i = 0; i < NCELL; i++) begin : g_cell
		alac_cell #(
			.STAGE (i)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.d      (chain[i]),
			.q      (chain[i+1])
		);
	end

	assign last = chain[NCELL];

	// Round the Q16 offsets to mm (half up) and form the centre.
	always_comb begin
		xr   = (35'(last.x) + 35'sd32768) >>> 16;
		yr   = (35'(last.y) + 35'sd32768) >>> 16;
		cn_w = 36'(last.pn) - 36'(xr);
		ce_w = 36'(last.pe) - 36'(yr);
		cd_w = 36'(last.pd) + 36'(offset_up_q);
		cn   = clamp32(cn_w, sat_n);
		ce   = clamp32(ce_w, sat_e);
		cd   = clamp32(cd_w, sat_d);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= last.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (last.corr) begin
				out_data_q <= {cd, ce, cn};
				out_sat_q  <= sat_n || sat_e || sat_d;
			end else begin
				out_data_q <= {last.pd, last.pe, last.pn};
				out_sat_q  <= 1'b0;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_sat_q;

	// A pass-through fix never reports a clamp.
	a_pass_no_sat: assert property (@(posedge clk) disable iff (!arst_n)
		en && last.valid && !last.corr |=> !m_tuser)
		else $error("saturated flag set on an uncorrected fix");

	// An accepted transfer occupies the entry slot on the next cycle.
	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> chain[0].valid)
		else $error("accepted transfer did not enter the cell chain");

	// A stalled chain holds its last slot, so no fix is lost at the output.
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(last.valid) && $stable(last.pn))
		else $error("cell chain moved while the result was stalled");

endmodule
`default_nettype wire
